// ===== design/fatlb_pkg.sv =====
package fatlb_pkg;

  localparam int ENTRIES      = 5;
  localparam int OFFSET_BITS  = 12;
  localparam int ADDRESS_BITS = 32;

  localparam int ADDRESS_W     = 32;
  localparam int PAGE_NUMBER_W = 20;
  localparam int PAGE_OFFSET_W = 12;
  localparam int SLOT_W        = 3;

  localparam int KEY_W   = (ADDRESS_BITS < ADDRESS_W) ? ADDRESS_BITS : ADDRESS_W;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int LIMIT_W = $clog2(ENTRIES + 1);
  localparam int COUNT_W = LIMIT_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam rank_t  LRU_RANK  = RANK_W'(ENTRIES - 1);
  localparam limit_t AGE_ALL   = LIMIT_W'(ENTRIES);
  localparam limit_t AGE_FULL  = LIMIT_W'(ENTRIES - 1);
  localparam count_t FULL_COUNT = COUNT_W'(ENTRIES);

  // Search results rippling along the row of entries.
  typedef struct packed {
    logic  found;
    idx_t  found_idx;
    rank_t found_rank;
    logic  lru_found;
    idx_t  lru_idx;
  } chain_t;

  // Update broadcast to every entry when a request is accepted.
  typedef struct packed {
    logic   en;
    logic   write;
    idx_t   target;
    limit_t limit;
  } update_t;

endpackage

// ===== design/fatlb_req_if.sv =====
interface fatlb_req_if;
  logic                            valid;
  logic                            ready;
  logic [fatlb_pkg::ADDRESS_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// ===== design/fatlb_rsp_if.sv =====
interface fatlb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [fatlb_pkg::PAGE_NUMBER_W-1:0] page_number;
  logic [fatlb_pkg::PAGE_OFFSET_W-1:0] page_offset;
  logic [fatlb_pkg::SLOT_W-1:0]        slot;
  logic                                replaced;

  modport source (
    output valid, output hit, output page_number, output page_offset,
    output slot, output replaced, input ready
  );
  modport sink (
    input valid, input hit, input page_number, input page_offset,
    input slot, input replaced, output ready
  );
endinterface

// ===== design/fatlb_cell.sv =====
module fatlb_cell (
  input  logic              clk,
  input  logic              rst,
  input  fatlb_pkg::idx_t   index,
  input  fatlb_pkg::key_t   key,
  input  fatlb_pkg::update_t upd,
  input  fatlb_pkg::chain_t chain_in,
  output fatlb_pkg::chain_t chain_out
);
  import fatlb_pkg::*;

  key_t  address;
  logic  valid;
  rank_t rank;

  logic match;
  logic is_lru;

  assign match  = valid && (address == key);
  assign is_lru = valid && (rank == LRU_RANK);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && match) begin
      chain_out.found      = 1'b1;
      chain_out.found_idx  = index;
      chain_out.found_rank = rank;
    end
    if (!chain_in.lru_found && is_lru) begin
      chain_out.lru_found = 1'b1;
      chain_out.lru_idx   = index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en) begin
      if (upd.target == index) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid && (LIMIT_W'(rank) < upd.limit)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.write && (upd.target == index)) begin
      address <= key;
    end
  end

endmodule

// ===== design/fully_associative_lru_tlb_unit.sv =====
// Channel  Direction  Fields
// req      in         address
// rsp      out        hit, page_number, page_offset, slot, replaced
//
// Each request is looked up and the table updated in the cycle it is accepted,
// so one request is taken per cycle; the search ripples through the row of entry
// cells in that same cycle. Its response appears in the output register on the
// next cycle. Reset clears all valid bits, ranks and the fill count. While the
// output register holds a response that is not taken, no new request is accepted.
module fully_associative_lru_tlb_unit (
  input logic clk,
  input logic rst,
  fatlb_req_if.sink   req,
  fatlb_rsp_if.source rsp
);
  import fatlb_pkg::*;

  chain_t  chain [ENTRIES+1];
  update_t upd;
  key_t    key;
  count_t  filled_count;
  logic    full;
  logic    accept;

  logic [ADDRESS_W-1:0] key_wide;
  logic [ADDRESS_W-1:0] shifted;

  assign key      = req.address[KEY_W-1:0];
  assign key_wide = ADDRESS_W'(key);
  assign shifted  = key_wide >> OFFSET_BITS;
  assign full     = (filled_count == FULL_COUNT);

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fatlb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (IDX_W'(i)),
      .key       (key),
      .upd       (upd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    upd.en = accept;
    if (chain[ENTRIES].found) begin
      upd.write  = 1'b0;
      upd.target = chain[ENTRIES].found_idx;
      upd.limit  = LIMIT_W'(chain[ENTRIES].found_rank);
    end else if (!full) begin
      upd.write  = 1'b1;
      upd.target = filled_count[IDX_W-1:0];
      upd.limit  = AGE_ALL;
    end else begin
      upd.write  = 1'b1;
      upd.target = chain[ENTRIES].lru_idx;
      upd.limit  = AGE_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (accept) begin
        rsp.valid <= 1'b1;
        if (!chain[ENTRIES].found && !full) begin
          filled_count <= filled_count + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.hit         <= chain[ENTRIES].found;
      rsp.page_number <= shifted[PAGE_NUMBER_W-1:0];
      rsp.page_offset <= PAGE_OFFSET_W'(key_wide & ((ADDRESS_W'(1) << OFFSET_BITS) - 1'b1));
      rsp.slot        <= SLOT_W'(upd.target);
      rsp.replaced    <= !chain[ENTRIES].found && full;
    end
  end

endmodule
